// ===== hw/rtl/pwsfr_pkg.sv =====
package pwsfr_pkg;

  localparam int DefaultFrameBits = 40;

  localparam int NumCfg  = 8;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 16;
  localparam int TimeW   = 32;
  localparam int ByteW   = 8;

  localparam int CmdDepth = 2;
  localparam int ResDepth = 2;

  localparam logic [CfgIdxW-1:0] CfgStartMin = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgStartMax = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgEarlyMin = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgEarlyMax = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgZeroMin  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgZeroMax  = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgOneMin   = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgOneMax   = 3'd7;

  localparam logic [CfgW-1:0] CfgReset [NumCfg] = '{
    16'd120, 16'd200, 16'd0, 16'd40, 16'd70, 16'd100, 16'd110, 16'd150
  };

  localparam logic OpArm  = 1'b0;
  localparam logic OpEdge = 1'b1;

  typedef enum logic [1:0] {
    StatusOk       = 2'd0,
    StatusTiming   = 2'd1,
    StatusChecksum = 2'd2
  } status_e;

  typedef struct packed {
    logic arm;
    logic in_start;
    logic in_early;
    logic in_zero;
    logic in_one;
  } cmd_t;

  typedef struct packed {
    status_e          status;
    logic [ByteW-1:0] humidity_whole;
    logic [ByteW-1:0] humidity_fraction;
    logic [ByteW-1:0] temperature_whole;
    logic [ByteW-1:0] temperature_fraction;
  } result_t;

endpackage

// ===== hw/rtl/pwsfr_fifo.sv =====
module pwsfr_fifo #(
  parameter int Width = 8,
  parameter int Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hw/rtl/pwsfr_front.sv =====
module pwsfr_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  input  logic                           operation_i,
  input  logic [pwsfr_pkg::TimeW-1:0]    capture_time_i,
  input  logic                           cfg_valid_i,
  input  logic [pwsfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pwsfr_pkg::CfgW-1:0]     cfg_data_i,
  input  logic                           cmd_full_i,
  output logic                           cmd_valid_o,
  output pwsfr_pkg::cmd_t                cmd_o
);

  import pwsfr_pkg::*;

  logic [CfgW-1:0]  cfg_q [NumCfg];
  logic [TimeW-1:0] prev_q, prev_d;
  logic [TimeW-1:0] dt;
  logic             acc;

  function automatic logic in_window(logic [TimeW-1:0] val, logic [CfgW-1:0] lo,
                                     logic [CfgW-1:0] hi);
    return (val >= TimeW'(lo)) && (val <= TimeW'(hi));
  endfunction

  assign acc         = push && !cmd_full_i;
  assign cmd_valid_o = acc;
  assign dt          = capture_time_i - prev_q;

  always_comb begin
    cmd_o.arm      = (operation_i == OpArm);
    cmd_o.in_start = in_window(dt, cfg_q[CfgStartMin], cfg_q[CfgStartMax]);
    cmd_o.in_early = in_window(dt, cfg_q[CfgEarlyMin], cfg_q[CfgEarlyMax]);
    cmd_o.in_zero  = in_window(dt, cfg_q[CfgZeroMin], cfg_q[CfgZeroMax]);
    cmd_o.in_one   = in_window(dt, cfg_q[CfgOneMin], cfg_q[CfgOneMax]);
  end

  // Idle edges are dropped by the back end and the next useful item is an arm,
  // so tracking every edge here gives the same intervals.
  always_comb begin
    prev_d = prev_q;
    if (acc) begin
      prev_d = (operation_i == OpArm) ? '0 : capture_time_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      cfg_q  <= CfgReset;
    end else begin
      prev_q <= prev_d;
      if (cfg_valid_i) begin
        cfg_q[cfg_index_i] <= cfg_data_i;
      end
    end
  end

endmodule

// ===== hw/rtl/pwsfr_back.sv =====
module pwsfr_back #(
  parameter int FrameBits = pwsfr_pkg::DefaultFrameBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  pwsfr_pkg::cmd_t    cmd_i,
  output logic               cmd_pop_o,
  input  logic               out_full_i,
  output logic               res_push_o,
  output pwsfr_pkg::result_t res_o
);

  import pwsfr_pkg::*;

  localparam int CntW = $clog2(FrameBits + 1);
  localparam int PadW = FrameBits + 5 * ByteW;
  localparam int Top  = PadW - 1;

  logic                 receiving_q, receiving_d;
  logic                 awaiting_q, awaiting_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [FrameBits-1:0] frame_q, frame_d, shifted;
  logic [PadW-1:0]      padded;
  logic [ByteW-1:0]     b0, b1, b2, b3, b4, sum;
  logic                 go;

  assign go        = cmd_valid_i && !out_full_i;
  assign cmd_pop_o = go;

  assign shifted = {frame_q[FrameBits-2:0], !cmd_i.in_zero};
  assign padded  = {shifted, {(5 * ByteW){1'b0}}};
  assign b0      = padded[Top -: ByteW];
  assign b1      = padded[Top - ByteW -: ByteW];
  assign b2      = padded[Top - 2 * ByteW -: ByteW];
  assign b3      = padded[Top - 3 * ByteW -: ByteW];
  assign b4      = padded[Top - 4 * ByteW -: ByteW];
  assign sum     = b0 + b1 + b2 + b3;

  always_comb begin
    receiving_d = receiving_q;
    awaiting_d  = awaiting_q;
    cnt_d       = cnt_q;
    frame_d     = frame_q;
    res_push_o  = 1'b0;
    res_o       = '0;
    res_o.status = StatusTiming;
    if (go) begin
      if (cmd_i.arm) begin
        receiving_d = 1'b1;
        awaiting_d  = 1'b1;
        cnt_d       = '0;
        frame_d     = '0;
      end else if (receiving_q) begin
        if (awaiting_q) begin
          if (cmd_i.in_start) begin
            awaiting_d = 1'b0;
          end else if (!cmd_i.in_early) begin
            receiving_d = 1'b0;
            awaiting_d  = 1'b0;
            res_push_o  = 1'b1;
          end
        end else if (cmd_i.in_zero || cmd_i.in_one) begin
          frame_d = shifted;
          cnt_d   = cnt_q + CntW'(1);
          if (cnt_q == CntW'(FrameBits - 1)) begin
            receiving_d = 1'b0;
            res_push_o  = 1'b1;
            if (sum == b4) begin
              res_o.status               = StatusOk;
              res_o.humidity_whole       = b0;
              res_o.humidity_fraction    = b1;
              res_o.temperature_whole    = b2;
              res_o.temperature_fraction = b3;
            end else begin
              res_o.status = StatusChecksum;
            end
          end
        end else begin
          receiving_d = 1'b0;
          res_push_o  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q <= 1'b0;
      awaiting_q  <= 1'b0;
      cnt_q       <= '0;
      frame_q     <= '0;
    end else begin
      receiving_q <= receiving_d;
      awaiting_q  <= awaiting_d;
      cnt_q       <= cnt_d;
      frame_q     <= frame_d;
    end
  end

  a_await_in_rx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    awaiting_q |-> receiving_q) else $error("waiting for start while idle");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(FrameBits)) else $error("bit count past frame length");

  a_res_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !out_full_i) else $error("result pushed into full queue");

  a_res_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |=> !receiving_q) else $error("still receiving after result");

endmodule

// ===== hw/rtl/pulse_width_sensor_frame_receiver_core.sv =====
// Result path: the interval is classified as an item is accepted and is written into the
// command queue; when the back end pops the item that ends the frame, the frame state
// updates and the result enters the result queue (empty low) at that same edge.
// Throughput: one item per cycle; a two-entry queue sits between classifier and frame state;
// a full two-entry result queue stalls the back end and input once the command queue fills.
// Reset: windows return to their defaults, both queues empty, receiver idle and unarmed.
module pulse_width_sensor_frame_receiver_core #(
  parameter int FrameBits = pwsfr_pkg::DefaultFrameBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic                          operation_i,
  input  logic [pwsfr_pkg::TimeW-1:0]   capture_time_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    status_o,
  output logic [pwsfr_pkg::ByteW-1:0]   humidity_whole_o,
  output logic [pwsfr_pkg::ByteW-1:0]   humidity_fraction_o,
  output logic [pwsfr_pkg::ByteW-1:0]   temperature_whole_o,
  output logic [pwsfr_pkg::ByteW-1:0]   temperature_fraction_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pwsfr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [pwsfr_pkg::CfgW-1:0]    cfg_data_i
);

  import pwsfr_pkg::*;

  cmd_t    cmd_wr, cmd_rd;
  result_t res_wr, res_rd;
  logic    cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic    res_push, res_full;

  assign cfg_ready_o = 1'b1;
  assign full        = cmd_full;

  pwsfr_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .operation_i    (operation_i),
    .capture_time_i (capture_time_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .cmd_full_i     (cmd_full),
    .cmd_valid_o    (cmd_push),
    .cmd_o          (cmd_wr)
  );

  pwsfr_fifo #(
    .Width ($bits(cmd_t)),
    .Depth (CmdDepth)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_wr),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rd),
    .empty_o (cmd_empty)
  );

  pwsfr_back #(
    .FrameBits (FrameBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_rd),
    .cmd_pop_o   (cmd_pop),
    .out_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_wr)
  );

  pwsfr_fifo #(
    .Width ($bits(result_t)),
    .Depth (ResDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_wr),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rd),
    .empty_o (empty)
  );

  assign status_o               = res_rd.status;
  assign humidity_whole_o       = res_rd.humidity_whole;
  assign humidity_fraction_o    = res_rd.humidity_fraction;
  assign temperature_whole_o    = res_rd.temperature_whole;
  assign temperature_fraction_o = res_rd.temperature_fraction;

endmodule
